/* hw/rtl/tldd_pkg.sv */
// Package for the two-digit LED multiplex driver: item types, kind codes,
// glyph patterns and the scan phase default. No dependencies.
package tldd_pkg;

    localparam int SCAN_PHASES_DEF = 6;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_SHOW  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic signed [7:0] number;
        logic             show_green;
        logic             show_red;
        logic             blink_request;
    } item_t;

    typedef struct packed {
        logic [3:0] anode_lines;
        logic [7:0] cathode_lines;
    } result_t;

    localparam logic [3:0] GLYPH_BLANK = 4'd10;
    localparam logic [3:0] GLYPH_E     = 4'd11;
    localparam logic [3:0] GLYPH_R     = 4'd12;

    function automatic logic [7:0] glyph(input logic [3:0] idx);
        logic [7:0] seg;
        unique case (idx)
            4'd0:    seg = 8'h7E;
            4'd1:    seg = 8'h48;
            4'd2:    seg = 8'hBC;
            4'd3:    seg = 8'hEC;
            4'd4:    seg = 8'hCA;
            4'd5:    seg = 8'hE6;
            4'd6:    seg = 8'hF6;
            4'd7:    seg = 8'h4E;
            4'd8:    seg = 8'hFE;
            4'd9:    seg = 8'hEE;
            GLYPH_E: seg = 8'hB6;
            GLYPH_R: seg = 8'h90;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

/* hw/rtl/tldd_digits.sv */
// Number to segment patterns for the left and right digit.
// Depends on tldd_pkg.
module tldd_digits
    import tldd_pkg::*;
(
    input  logic signed [7:0] number,
    output logic [7:0]        left_seg,
    output logic [7:0]        right_seg
);

    logic        neg;
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [7:0]  tens_x10;
    logic [3:0]  units;
    logic [3:0]  left_idx;
    logic [3:0]  right_idx;

    assign neg      = number[7];
    assign mag      = neg ? 8'(-number) : number;
    // divide by ten: exact for values below 160
    assign prod     = 16'(mag) * 16'd205;
    assign tens     = prod[14:11];
    assign tens_x10 = {tens, 3'b000} + {3'b000, tens, 1'b0};
    assign units    = 4'(mag - tens_x10);

    always_comb
    begin
        priority if (mag <= 8'd9)
        begin
            right_idx = mag[3:0];
            left_idx  = GLYPH_BLANK;
        end
        else if (mag <= 8'd99)
        begin
            right_idx = units;
            left_idx  = tens;
        end
        else
        begin
            right_idx = GLYPH_R;
            left_idx  = GLYPH_E;
        end
    end

    assign right_seg = glyph(right_idx);
    assign left_seg  = glyph(left_idx) | {7'd0, neg};

endmodule

/* hw/rtl/tldd_core.sv */
// Display state: segment store, blink flag, scan phase, blink counter and
// port levels. Depends on tldd_pkg and tldd_digits.
module tldd_core
    import tldd_pkg::*;
#(
    parameter int SCAN_PHASES = SCAN_PHASES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    localparam int PW = $clog2(SCAN_PHASES);

    logic [7:0]    seg_reg [4];
    logic [7:0]    seg_next [4];
    logic          blink_en_reg;
    logic          blink_en_next;
    logic [PW-1:0] phase_reg;
    logic [PW-1:0] phase_next;
    logic [7:0]    count_reg;
    logic [7:0]    count_next;
    logic [3:0]    anode_reg;
    logic [3:0]    anode_next;
    logic [7:0]    cathode_reg;
    logic [7:0]    cathode_next;
    logic [7:0]    left_seg;
    logic [7:0]    right_seg;
    logic [1:0]    sel;

    tldd_digits u_digits
    (
        .number    (item.number),
        .left_seg  (left_seg),
        .right_seg (right_seg)
    );

    assign sel = phase_next[1:0];

    always_comb
    begin
        seg_next      = seg_reg;
        blink_en_next = blink_en_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        anode_next    = anode_reg;
        cathode_next  = cathode_reg;
        unique case (item.kind)
            KIND_TICK:
            begin
                count_next   = count_reg + 8'd1;
                phase_next   = (phase_reg == PW'(SCAN_PHASES - 1)) ? '0 : phase_reg + 1'b1;
                cathode_next = 8'hFF;
                if (!blink_en_reg || count_next[7:6] != 2'b00)
                begin
                    anode_next   = 4'b0001 << sel;
                    cathode_next = ~seg_reg[sel];
                end
            end
            KIND_SHOW:
            begin
                seg_next[0]   = item.show_green ? left_seg  : 8'h00;
                seg_next[1]   = item.show_green ? right_seg : 8'h00;
                seg_next[2]   = item.show_red   ? left_seg  : 8'h00;
                seg_next[3]   = item.show_red   ? right_seg : 8'h00;
                blink_en_next = item.blink_request;
            end
            KIND_CLEAR:
            begin
                seg_next = '{default: 8'h00};
            end
            default:
            begin
                seg_next = seg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg      <= '{default: 8'h00};
            blink_en_reg <= 1'b0;
            phase_reg    <= '0;
            count_reg    <= 8'd0;
            anode_reg    <= 4'd0;
            cathode_reg  <= 8'd0;
        end
        else if (step)
        begin
            seg_reg      <= seg_next;
            blink_en_reg <= blink_en_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            anode_reg    <= anode_next;
            cathode_reg  <= cathode_next;
        end
    end

    assign result.anode_lines   = anode_next;
    assign result.cathode_lines = cathode_next;

endmodule

/* hw/rtl/two_digit_led_mux_driver.sv */
// Top level of the two-digit, two-color LED multiplex driver: input register,
// display core and result register. Depends on tldd_pkg and tldd_core.
//
//  channel  | dir | tdata (low bit up)                                 | tuser
//  s_axis   | in  | number[7:0], show_green, show_red, blink_request   | kind[1:0]
//  m_axis   | out | anode_lines[3:0], cathode_lines[7:0]               | -
//
// One item per cycle while m_axis does not stall; the input register takes an
// item at the accepting edge and the core update loads the result register when
// the item advances, so the result passes the input register, then the result one.
// Reset clears the segment store, counters, port levels and both valid flags.
// A stall on m_axis holds the result and, through the input register, backs
// up into s_axis_tready in the same cycle.
module two_digit_led_mux_driver
    import tldd_pkg::*;
#(
    parameter int SCAN_PHASES = SCAN_PHASES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // number[7:0], show_green, show_red, blink_request, 0
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // anode_lines[3:0], cathode_lines[7:0], 0
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    item_t   in_item;
    logic    advance;
    result_t result;
    logic    out_valid_reg;
    result_t out_reg;

    assign in_item.kind          = kind_t'(s_axis_tuser);
    assign in_item.number        = s_axis_tdata[7:0];
    assign in_item.show_green    = s_axis_tdata[8];
    assign in_item.show_red      = s_axis_tdata[9];
    assign in_item.blink_request = s_axis_tdata[10];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item;
        end
    end

    tldd_core #(
        .SCAN_PHASES (SCAN_PHASES)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.cathode_lines, out_reg.anode_lines};

endmodule

/* tb/sv/tb_two_digit_led_mux_driver.sv */
// Self-checking testbench for two_digit_led_mux_driver: drives show, clear, tick and
// unused-kind items and checks every port level item against an in-bench display model.
// Depends on tldd_pkg and the driver RTL only.
module tb_two_digit_led_mux_driver
    import tldd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SCAN_PHASES = SCAN_PHASES_DEF;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 5000;
    localparam int         BLINK_HIDE  = 64;
    localparam int         HOLD_CYCLES = 200;

    localparam logic [7:0] SEGMENT_GLYPH [13] = '{
        8'h7E, 8'h48, 8'hBC, 8'hEC, 8'hCA, 8'hE6, 8'hF6, 8'h4E, 8'hFE, 8'hEE,
        8'h00, 8'hB6, 8'h90
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // number[7:0], show_green, show_red, blink_request, 0
    logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // anode_lines[3:0], cathode_lines[7:0], 0

    two_digit_led_mux_driver #(.SCAN_PHASES(SCAN_PHASES)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // display model state
    logic [7:0] seg_store [4];
    logic       blink_on;
    logic [2:0] scan_phase;
    logic [7:0] blink_cnt;
    logic [3:0] anode_level;
    logic [7:0] cathode_level;

    result_t expected_levels [$];

    int errors = 0;
    int items_sent = 0;
    int levels_checked = 0;
    int shows_sent = 0;
    int ticks_sent = 0;
    int hidden_ticks = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    task automatic update_display(input logic [1:0] kind, input logic [7:0] number,
                                  input logic green, input logic red, input logic blink);
        logic       neg;
        logic [7:0] mag;
        logic [7:0] left_seg;
        logic [7:0] right_seg;
        logic [1:0] sel;
        result_t    lv;
        neg = number[7];
        mag = neg ? (8'd0 - number) : number;
        if (kind == KIND_TICK) begin
            blink_cnt = blink_cnt + 8'd1;
            scan_phase = 3'((int'(scan_phase) + 1) % SCAN_PHASES);
            cathode_level = 8'hFF;
            if (!blink_on || blink_cnt >= BLINK_HIDE) begin
                sel = scan_phase[1:0];
                anode_level = 4'(1 << sel);
                cathode_level = ~seg_store[sel];
            end else begin
                hidden_ticks++;
            end
        end else if (kind == KIND_SHOW) begin
            if (mag <= 8'd9) begin
                right_seg = SEGMENT_GLYPH[mag];
                left_seg  = SEGMENT_GLYPH[GLYPH_BLANK];
            end else if (mag <= 8'd99) begin
                right_seg = SEGMENT_GLYPH[mag % 10];
                left_seg  = SEGMENT_GLYPH[mag / 10];
            end else begin
                right_seg = SEGMENT_GLYPH[GLYPH_R];
                left_seg  = SEGMENT_GLYPH[GLYPH_E];
            end
            left_seg = left_seg | {7'd0, neg};
            seg_store[0] = green ? left_seg : 8'h00;
            seg_store[1] = green ? right_seg : 8'h00;
            seg_store[2] = red ? left_seg : 8'h00;
            seg_store[3] = red ? right_seg : 8'h00;
            blink_on = blink;
        end else if (kind == KIND_CLEAR) begin
            for (int i = 0; i < 4; i++)
                seg_store[i] = 8'h00;
        end
        lv.anode_lines = anode_level;
        lv.cathode_lines = cathode_level;
        expected_levels.push_back(lv);
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [7:0] number,
                             input logic green, input logic red, input logic blink);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'd0, blink, red, green, number};
        do
            @(posedge clk);
        while (!s_axis_tready);
        update_display(kind, number, green, red, blink);
        items_sent++;
        if (kind == KIND_SHOW)
            shows_sent++;
        if (kind == KIND_TICK)
            ticks_sent++;
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_item(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    function automatic logic [7:0] pick_number();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return 8'($urandom_range(18) - 9);
        else if (roll < 65)
            return 8'($urandom_range(198) - 99);
        else if (roll < 75)
            return 8'($urandom_range(1) ? $urandom_range(127, 100) : -$urandom_range(128, 100));
        else
            return 8'($urandom);
    endfunction

    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
        end
        if (m_axis_tvalid && m_axis_tready) begin
            got.anode_lines = m_axis_tdata[3:0];
            got.cathode_lines = m_axis_tdata[11:4];
            levels_checked++;
            if (expected_levels.size() == 0) begin
                errors++;
                $display("%0t: unexpected item anode=%h cathode=%h", $time,
                         got.anode_lines, got.cathode_lines);
            end else begin
                want = expected_levels.pop_front();
                if (got.anode_lines !== want.anode_lines) begin
                    errors++;
                    $display("%0t: anode_lines expected %h actual %h", $time,
                             want.anode_lines, got.anode_lines);
                end
                if (got.cathode_lines !== want.cathode_lines) begin
                    errors++;
                    $display("%0t: cathode_lines expected %h actual %h", $time,
                             want.cathode_lines, got.cathode_lines);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("tb_two_digit_led_mux_driver NOT OK");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(KIND_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_item(KIND_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        send_item(KIND_SHOW, 8'sd127, 1'b1, 1'b1, 1'b0);
        send_ticks(4);
        send_item(KIND_SHOW, -8'sd99, 1'b1, 1'b0, 1'b0);
        send_ticks(2);
        send_item(KIND_SHOW, -8'sd5, 1'b0, 1'b1, 1'b0);
        send_ticks(4);
        send_item(KIND_SHOW, 8'sd0, 1'b0, 1'b0, 1'b0);
        send_ticks(1);
        send_item(KIND_SHOW, 8'sd99, 1'b1, 1'b1, 1'b0);
        send_item(KIND_CLEAR, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_ticks(1);
        send_item(KIND_SHOW, -8'sd128, 1'b1, 1'b1, 1'b1);
        send_ticks(3);
        send_item(KIND_SHOW, 8'sd10, 1'b1, 1'b1, 1'b0);
        send_ticks(1);
    endtask

    task automatic run_traffic(input int count);
        int stop_at;
        int roll;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                send_item(KIND_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom));
            end else if (roll < 9) begin
                send_item(KIND_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom));
            end else begin
                send_item(KIND_SHOW, pick_number(), 1'($urandom), 1'($urandom),
                          1'($urandom));
                send_ticks($urandom_range(1, 16));
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        send_item(KIND_SHOW, -8'sd42, 1'b1, 1'b1, 1'b0);
        send_ticks(30);
    endtask

    task automatic test_idle_phases();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_traffic(460);
        src_idle_pct = 76;
        run_traffic(460);
        src_idle_pct = 0;
        sink_stall_pct = 76;
        run_traffic(460);
        src_idle_pct = 32;
        sink_stall_pct = 32;
        run_traffic(460);
        src_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        for (int i = 0; i < 4; i++)
            seg_store[i] = 8'h00;
        blink_on = 1'b0;
        scan_phase = '0;
        blink_cnt = '0;
        anode_level = '0;
        cathode_level = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_idle_phases();

        s_axis_tvalid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d items: %0d shows, %0d ticks (%0d hidden by blink), rest clear/unused.",
                 items_sent, shows_sent, ticks_sent, hidden_ticks);
        $display("Checked %0d port level items over four idle/stall mixes and one long hold-off.",
                 levels_checked);
        if (errors == 0)
            $display("tb_two_digit_led_mux_driver OK");
        else
            $display("tb_two_digit_led_mux_driver NOT OK");
        $finish;
    end

endmodule
